### sv/spq_pkg.sv
// Package for the sorted priority queue: widths, operation codes and cell control.
package spq_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int DATA_W           = 32;
    localparam int COUNT_W          = 5;

    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    // Operation broadcast to every cell in a cycle.
    typedef struct packed {
        logic enq;  // insert the incoming entry
        logic deq;  // shift everything one place toward the head
    } spq_ctrl_t;

endpackage

### sv/spq_cell.sv
// One slot of the sorted shift-register queue: holds an entry and trades with its neighbors.
module spq_cell #(
    parameter bit IS_HEAD = 1'b0
) (
    input  logic                            clk,
    input  spq_pkg::spq_ctrl_t              ctrl,
    input  logic                            occupied,
    input  logic                            left_ahead,
    input  logic signed [spq_pkg::DATA_W-1:0] new_value,
    input  logic signed [spq_pkg::DATA_W-1:0] new_priority,
    input  logic signed [spq_pkg::DATA_W-1:0] left_value,
    input  logic signed [spq_pkg::DATA_W-1:0] left_priority,
    input  logic signed [spq_pkg::DATA_W-1:0] right_value,
    input  logic signed [spq_pkg::DATA_W-1:0] right_priority,
    output logic                            ahead,
    output logic signed [spq_pkg::DATA_W-1:0] value,
    output logic signed [spq_pkg::DATA_W-1:0] priority_q
);
    import spq_pkg::*;

    logic signed [DATA_W-1:0] value_reg, value_next;
    logic signed [DATA_W-1:0] prio_reg, prio_next;

    // Entry stays ahead of the newcomer; the head also keeps its place on a tie.
    always_comb
    begin
        if (IS_HEAD)
            ahead = occupied && (prio_reg >= new_priority);
        else
            ahead = occupied && (prio_reg > new_priority);
    end

    always_comb
    begin
        value_next = value_reg;
        prio_next  = prio_reg;
        if (ctrl.enq)
        begin
            if (!ahead)
            begin
                if (left_ahead)
                begin
                    value_next = new_value;
                    prio_next  = new_priority;
                end
                else
                begin
                    value_next = left_value;
                    prio_next  = left_priority;
                end
            end
        end
        else if (ctrl.deq)
        begin
            value_next = right_value;
            prio_next  = right_priority;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

    assign value      = value_reg;
    assign priority_q = prio_reg;

endmodule

### sv/sorted_priority_queue.sv
// Top level of the sorted priority queue: a row of cells, the fill count and the result register.
//
// Bounded max-priority queue held as a row of CAPACITY cells kept in descending
// priority order, cell 0 being the head. Each word presented with start high is
// taken at that clock edge (busy is always low, so a word can be given every
// cycle): func selects enqueue of item_value/item_priority or dequeue of the
// head. Every cell compares its priority with the incoming one in parallel and
// either keeps its entry, takes the new one, or takes its neighbor's. Exactly
// one result word follows per input word, on the cycle after it was taken,
// marked by done for that single cycle; the receiver cannot stall it, so it
// must capture the result then. The result gives the head entry (zeros when
// empty), is_empty, entry_count and rejected, which flags an enqueue dropped
// because the queue was full. A new entry goes behind existing entries of
// higher priority and ahead of equal ones, except that an entry at the head
// keeps its place against an equal newcomer. A dequeue on an empty queue is
// ignored. Stored entries carry no reset; only slots below the fill count are
// ever looked at.
module sorted_priority_queue #(
    parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              func,
    input  logic signed [spq_pkg::DATA_W-1:0] item_value,
    input  logic signed [spq_pkg::DATA_W-1:0] item_priority,
    output logic                              done,
    output logic signed [spq_pkg::DATA_W-1:0] head_value,
    output logic signed [spq_pkg::DATA_W-1:0] head_priority,
    output logic                              is_empty,
    output logic [spq_pkg::COUNT_W-1:0]       entry_count,
    output logic                              rejected
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             done_reg;
    logic             rejected_reg, rejected_next;
    logic             full;
    logic             nonempty;
    spq_ctrl_t        ctrl;

    logic                     cell_ahead [CAPACITY];
    logic signed [DATA_W-1:0] cell_value [CAPACITY];
    logic signed [DATA_W-1:0] cell_prio  [CAPACITY];

    // Every word is taken as it comes.
    assign busy = 1'b0;

    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign nonempty = (count_reg != '0);

    always_comb
    begin
        ctrl.enq      = start && (func == FUNC_ENQ) && !full;
        ctrl.deq      = start && (func == FUNC_DEQ) && nonempty;
        rejected_next = start && (func == FUNC_ENQ) && full;
        count_next    = count_reg;
        if (ctrl.enq)
            count_next = count_reg + CNT_W'(1);
        else if (ctrl.deq)
            count_next = count_reg - CNT_W'(1);
    end

    // The row of cells. Cell 0 is the head; the left neighbor of cell 0 is the
    // incoming word, which always counts as ahead. The last cell reloads itself
    // on a dequeue since its contents fall outside the count anyway.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                     left_ahead;
        logic signed [DATA_W-1:0] left_value, left_prio;
        logic signed [DATA_W-1:0] right_value, right_prio;

        if (i == 0)
        begin : g_first
            assign left_ahead = 1'b1;
            assign left_value = item_value;
            assign left_prio  = item_priority;
        end
        else
        begin : g_inner
            assign left_ahead = cell_ahead[i-1];
            assign left_value = cell_value[i-1];
            assign left_prio  = cell_prio[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_value = cell_value[i];
            assign right_prio  = cell_prio[i];
        end
        else
        begin : g_mid
            assign right_value = cell_value[i+1];
            assign right_prio  = cell_prio[i+1];
        end

        spq_cell #(
            .IS_HEAD (i == 0)
        ) u_cell (
            .clk            (clk),
            .ctrl           (ctrl),
            .occupied       (CNT_W'(i) < count_reg),
            .left_ahead     (left_ahead),
            .new_value      (item_value),
            .new_priority   (item_priority),
            .left_value     (left_value),
            .left_priority  (left_prio),
            .right_value    (right_value),
            .right_priority (right_prio),
            .ahead          (cell_ahead[i]),
            .value          (cell_value[i]),
            .priority_q     (cell_prio[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            done_reg     <= 1'b0;
            rejected_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            done_reg     <= start;
            rejected_reg <= rejected_next;
        end
    end

    // Result word: read straight off the head cell and the count.
    assign done          = done_reg;
    assign head_value    = nonempty ? cell_value[0] : '0;
    assign head_priority = nonempty ? cell_prio[0] : '0;
    assign is_empty      = !nonempty;
    assign entry_count   = COUNT_W'(count_reg);
    assign rejected      = rejected_reg;

endmodule

### sim/tb.sv
// Self-checking testbench for the sorted priority queue.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    // Safety net for a hung run: about 530 words with the idle gaps below are sent,
    // and this allows many times the slowest correct run.
    localparam int CYCLE_LIMIT = 100000;
    localparam int CAP         = DEFAULT_CAPACITY;

    // What the block must report after one word.
    typedef struct {
        logic signed [DATA_W-1:0] head_value;
        logic signed [DATA_W-1:0] head_priority;
        logic                     is_empty;
        logic [COUNT_W-1:0]       entry_count;
        logic                     rejected;
    } head_report_t;

    // Mirror of the queue contents plus the reports still owed by the block.
    class queue_mirror;
        logic signed [DATA_W-1:0] vals [CAP];
        logic signed [DATA_W-1:0] pris [CAP];
        int                       fill;
        head_report_t             pending_heads[$];
        int                       mismatches;

        function new();
            fill       = 0;
            mismatches = 0;
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("MISMATCH at %0t: %s", $realtime, what);
        endtask

        // Apply one accepted word to the mirror and queue the report it implies.
        function void note_word(logic fn, logic signed [DATA_W-1:0] v,
                                logic signed [DATA_W-1:0] p);
            int           pos;
            int           i;
            head_report_t r;
            r.rejected = 1'b0;
            if (fn == FUNC_ENQ)
            begin
                if (fill >= CAP)
                begin
                    r.rejected = 1'b1;
                end
                else
                begin
                    pos = 0;
                    while (pos < fill && pris[pos] > p)
                        pos++;
                    // head keeps its place against an equal newcomer
                    if (pos == 0 && fill > 0 && pris[0] == p)
                        pos = 1;
                    for (i = fill; i > pos; i--)
                    begin
                        vals[i] = vals[i-1];
                        pris[i] = pris[i-1];
                    end
                    vals[pos] = v;
                    pris[pos] = p;
                    fill++;
                end
            end
            else if (fill > 0)
            begin
                for (i = 1; i < fill; i++)
                begin
                    vals[i-1] = vals[i];
                    pris[i-1] = pris[i];
                end
                fill--;
            end
            if (fill > 0)
            begin
                r.head_value    = vals[0];
                r.head_priority = pris[0];
                r.is_empty      = 1'b0;
            end
            else
            begin
                r.head_value    = '0;
                r.head_priority = '0;
                r.is_empty      = 1'b1;
            end
            r.entry_count = COUNT_W'(fill);
            pending_heads.push_back(r);
        endfunction

        task check_word(logic signed [DATA_W-1:0] hv, logic signed [DATA_W-1:0] hp,
                        logic emp, logic [COUNT_W-1:0] cnt, logic rej);
            head_report_t w;
            if (pending_heads.size() == 0)
            begin
                report_mismatch("result word with nothing pending");
                return;
            end
            w = pending_heads.pop_front();
            if (hv !== w.head_value)
                report_mismatch($sformatf("head_value got %0d want %0d", hv, w.head_value));
            if (hp !== w.head_priority)
                report_mismatch($sformatf("head_priority got %0d want %0d",
                                          hp, w.head_priority));
            if (emp !== w.is_empty)
                report_mismatch($sformatf("is_empty got %b want %b", emp, w.is_empty));
            if (cnt !== w.entry_count)
                report_mismatch($sformatf("entry_count got %0d want %0d",
                                          cnt, w.entry_count));
            if (rej !== w.rejected)
                report_mismatch($sformatf("rejected got %b want %b", rej, w.rejected));
        endtask
    endclass

    logic                     clk           = 1'b0;
    logic                     rst_n         = 1'b0;
    logic                     start         = 1'b0;
    logic                     func          = FUNC_ENQ;
    logic signed [DATA_W-1:0] item_value    = '0;
    logic signed [DATA_W-1:0] item_priority = '0;
    logic                     busy;
    logic                     done;
    logic signed [DATA_W-1:0] head_value;
    logic signed [DATA_W-1:0] head_priority;
    logic                     is_empty;
    logic [COUNT_W-1:0]       entry_count;
    logic                     rejected;

    queue_mirror board = new();
    int unsigned cycles = 0;

    sorted_priority_queue uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .item_value    (item_value),
        .item_priority (item_priority),
        .done          (done),
        .head_value    (head_value),
        .head_priority (head_priority),
        .is_empty      (is_empty),
        .entry_count   (entry_count),
        .rejected      (rejected)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Watchdog: a stuck handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    // Monitor. Both sides are sampled at the rising edge, where every value is
    // still the one from the cycle that edge closes. A result word is checked
    // before a word taken at the same edge is noted; a result can only belong
    // to a word taken at an earlier edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                board.check_word(head_value, head_priority, is_empty, entry_count, rejected);
            if (start && !busy)
                board.note_word(func, item_value, item_priority);
        end
    end

    // Present one word and return at the edge that takes it. Start is left high
    // so back-to-back words keep it asserted without a glitch.
    task automatic send_word(logic fn, logic signed [DATA_W-1:0] v,
                             logic signed [DATA_W-1:0] p);
        start         <= 1'b1;
        func          <= fn;
        item_value    <= v;
        item_priority <= p;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic hold_off(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Stop sending and wait until every owed result word has come back. The
    // pending count is looked at on the falling edge, away from the monitor.
    task automatic drain();
        start <= 1'b0;
        do
            @(negedge clk);
        while (board.pending_heads.size() != 0);
        @(posedge clk);
    endtask

    // Small priorities (-3 to 3) in four draws of ten so ties (at the head and
    // deeper) are common, extremes in one, the rest anywhere in the 32-bit range.
    function automatic logic signed [DATA_W-1:0] pick_priority();
        logic signed [DATA_W-1:0] p;
        case ($urandom_range(9)) inside
            [0:3]: p = $signed(DATA_W'($urandom_range(6))) - 3;
            4:
            begin
                case ($urandom_range(3))
                    0:       p = 32'sh7FFF_FFFF;
                    1:       p = 32'sh8000_0000;
                    2:       p = '0;
                    default: p = -1;
                endcase
            end
            default: p = $urandom;
        endcase
        return p;
    endfunction

    // Random words. The enqueue share swings every 40 words between filling,
    // balanced and draining, so the queue keeps running into full and empty.
    // The sender idles for about idle_pct percent of the time.
    task automatic run_random(int n, int idle_pct);
        int   k;
        int   enq_pct;
        logic fn;
        enq_pct = 50;
        for (k = 0; k < n; k++)
        begin
            if (k % 40 == 0)
            begin
                case ($urandom_range(2))
                    0:       enq_pct = 85;
                    1:       enq_pct = 50;
                    default: enq_pct = 15;
                endcase
            end
            fn = ($urandom_range(99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ;
            while ($urandom_range(99) < idle_pct)
                hold_off(1);
            send_word(fn, $urandom, pick_priority());
        end
    endtask

    // Corners: empty dequeue, extreme values, ties at the head and behind it,
    // filling up, enqueues into a full queue, then part of the drain.
    task automatic run_directed();
        int k;
        send_word(FUNC_DEQ, 5, 5);
        send_word(FUNC_ENQ, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_word(FUNC_ENQ, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);   // ties the head
        send_word(FUNC_ENQ, 11, 32'sh8000_0000);
        send_word(FUNC_ENQ, 12, 32'sh8000_0000);               // ties a non-head entry
        send_word(FUNC_ENQ, -1, 0);
        for (k = 0; k < 11; k++)
            send_word(FUNC_ENQ, 100 + k, $signed(DATA_W'($urandom_range(20))) - 10);
        send_word(FUNC_ENQ, 99, 32'sh7FFF_FFFF);               // full: dropped
        send_word(FUNC_ENQ, 98, 32'sh8000_0000);               // full: dropped
        for (k = 0; k < 5; k++)
            send_word(FUNC_DEQ, -k, k);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        drain();                  // sender waits for every owed result at least once
        run_random(170, 9);
        drain();
        run_random(170, 74);
        drain();
        run_random(170, 0);       // back-to-back, no gaps
        drain();

        // extra edges catch any stray result word
        repeat (4) @(posedge clk);
        if (board.mismatches == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
